// ----- rtl/ptss_pkg.sv -----
`timescale 1ns / 1ps

package ptss_pkg;

  // Actuator modes, one-hot.
  typedef enum logic [5:0] {
    MODE_IDLE_ON     = 6'b000001,
    MODE_IDLE_OFF    = 6'b000010,
    MODE_TURNING_ON  = 6'b000100,
    MODE_ON_TO_IDLE  = 6'b001000,
    MODE_TURNING_OFF = 6'b010000,
    MODE_OFF_TO_IDLE = 6'b100000
  } mode_t;

  // Mode codes as they appear on the result port.
  localparam logic [2:0] CODE_IDLE_ON     = 3'd0;
  localparam logic [2:0] CODE_IDLE_OFF    = 3'd1;
  localparam logic [2:0] CODE_TURNING_ON  = 3'd2;
  localparam logic [2:0] CODE_ON_TO_IDLE  = 3'd3;
  localparam logic [2:0] CODE_TURNING_OFF = 3'd4;
  localparam logic [2:0] CODE_OFF_TO_IDLE = 3'd5;

  // Configuration register indexes.
  localparam logic [2:0] REG_RUN_THRESHOLD = 3'd0;
  localparam logic [2:0] REG_COOLOFF_TICKS = 3'd1;
  localparam logic [2:0] REG_STEP_TICKS    = 3'd2;
  localparam logic [2:0] REG_DUTY_LOW      = 3'd3;
  localparam logic [2:0] REG_DUTY_HIGH     = 3'd4;
  localparam logic [2:0] REG_DUTY_REST     = 3'd5;

  // Reset values of the registers.
  localparam logic [7:0]  RST_RUN_THRESHOLD = 8'd10;
  localparam logic [15:0] RST_COOLOFF_TICKS = 16'd976;
  localparam logic [15:0] RST_STEP_TICKS    = 16'd585;
  localparam logic [7:0]  RST_DUTY_LOW      = 8'd4;
  localparam logic [7:0]  RST_DUTY_HIGH     = 8'd6;
  localparam logic [7:0]  RST_DUTY_REST     = 8'd5;

  // A duty write only lands when the new value lies within min..max.
  function automatic logic [7:0] duty_write(input logic [7:0] value,
                                            input logic [7:0] current,
                                            input logic [7:0] lo,
                                            input logic [7:0] hi);
    logic [7:0] result;
    result = current;
    if (value >= lo && value <= hi) begin
      result = value;
    end
    return result;
  endfunction

  function automatic logic [2:0] mode_code(input mode_t mode);
    logic [2:0] code;
    unique case (mode)
      MODE_IDLE_ON:     code = CODE_IDLE_ON;
      MODE_IDLE_OFF:    code = CODE_IDLE_OFF;
      MODE_TURNING_ON:  code = CODE_TURNING_ON;
      MODE_ON_TO_IDLE:  code = CODE_ON_TO_IDLE;
      MODE_TURNING_OFF: code = CODE_TURNING_OFF;
      MODE_OFF_TO_IDLE: code = CODE_OFF_TO_IDLE;
      default:          code = CODE_IDLE_OFF;
    endcase
    return code;
  endfunction

endpackage

// ----- rtl/pulse_toggled_servo_sweeper_unit.sv -----
`timescale 1ns / 1ps

// Pulse-toggled servo sweeper. Each request is one tick carrying the sensor
// level and yields exactly one result: the duty value, actuator mode, whether
// a pulse was accepted on this tick and whether the receiver is cooling off.
// A tick is taken every clock cycle unless the input is stalled; the whole tick
// update (receiver, then actuator) is evaluated combinationally from the state
// registers, and the result lands in an output register in the cycle after the
// request is accepted. The input is stalled only while that output register
// holds a result that the downstream side is stalling. Configuration writes are
// always ready and apply from the next tick; write them only while the block is idle.
module pulse_toggled_servo_sweeper_unit
  import ptss_pkg::*;
(
  input  logic        clk,
  input  logic        rst,

  input  logic        in_valid,
  output logic        in_stall,
  input  logic        sensor_active,

  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  duty_out,
  output logic [2:0]  actuator_mode_out,
  output logic        pulse_accepted,
  output logic        cooling_off,

  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  // Configuration registers.
  logic [7:0]  run_threshold;
  logic [15:0] cooloff_ticks;
  logic [15:0] step_ticks;
  logic [7:0]  duty_low;
  logic [7:0]  duty_high;
  logic [7:0]  duty_rest;

  // Tick state.
  logic [7:0]  pulse_run_length, pulse_run_length_next;
  logic [15:0] cooloff_count, cooloff_count_next;
  logic        cooling_flag, cooling_flag_next;
  mode_t       actuator_mode, actuator_mode_next;
  logic [15:0] step_countdown, step_countdown_next;
  logic [7:0]  duty_level, duty_level_next;

  // Intermediate values after the receiver's part of the tick.
  mode_t       mode_rx;
  logic [15:0] countdown_rx;
  logic [7:0]  duty_rx;
  logic        accepted;
  logic        in_take;

  assign cfg_ready = 1'b1;
  assign in_stall  = out_valid & out_stall;
  assign in_take   = in_valid & ~in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      run_threshold <= RST_RUN_THRESHOLD;
      cooloff_ticks <= RST_COOLOFF_TICKS;
      step_ticks    <= RST_STEP_TICKS;
      duty_low      <= RST_DUTY_LOW;
      duty_high     <= RST_DUTY_HIGH;
      duty_rest     <= RST_DUTY_REST;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_RUN_THRESHOLD: run_threshold <= cfg_data[7:0];
        REG_COOLOFF_TICKS: cooloff_ticks <= cfg_data;
        REG_STEP_TICKS:    step_ticks    <= cfg_data;
        REG_DUTY_LOW:      duty_low      <= cfg_data[7:0];
        REG_DUTY_HIGH:     duty_high     <= cfg_data[7:0];
        REG_DUTY_REST:     duty_rest     <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  // Receiver, including the nudge that an accepted pulse gives an idle actuator.
  always_comb begin
    pulse_run_length_next = pulse_run_length;
    cooloff_count_next    = cooloff_count;
    cooling_flag_next     = cooling_flag;
    mode_rx               = actuator_mode;
    countdown_rx          = step_countdown;
    duty_rx               = duty_level;
    accepted              = 1'b0;
    if (cooling_flag) begin
      if (cooloff_count == 16'd0) begin
        cooling_flag_next = 1'b0;
      end else begin
        cooloff_count_next = cooloff_count - 16'd1;
      end
    end else if (sensor_active) begin
      if (pulse_run_length >= run_threshold) begin
        accepted              = 1'b1;
        pulse_run_length_next = 8'd0;
        cooling_flag_next     = 1'b1;
        cooloff_count_next    = cooloff_ticks;
        if (actuator_mode == MODE_IDLE_ON) begin
          duty_rx      = duty_write(duty_level - 8'd1, duty_level, duty_low, duty_high);
          mode_rx      = MODE_TURNING_OFF;
          countdown_rx = step_ticks;
        end else if (actuator_mode == MODE_IDLE_OFF) begin
          duty_rx      = duty_write(duty_level + 8'd1, duty_level, duty_low, duty_high);
          mode_rx      = MODE_TURNING_ON;
          countdown_rx = step_ticks;
        end
      end else begin
        pulse_run_length_next = pulse_run_length + 8'd1;
      end
    end else begin
      pulse_run_length_next = 8'd0;
    end
  end

  // Actuator step, working on what the receiver left this tick.
  always_comb begin
    actuator_mode_next  = mode_rx;
    step_countdown_next = countdown_rx;
    duty_level_next     = duty_rx;
    if (mode_rx != MODE_IDLE_ON && mode_rx != MODE_IDLE_OFF) begin
      if (countdown_rx != 16'd0) begin
        step_countdown_next = countdown_rx - 16'd1;
      end else begin
        unique case (mode_rx)
          MODE_TURNING_ON: begin
            step_countdown_next = step_ticks;
            if (duty_rx != duty_high) begin
              duty_level_next = duty_write(duty_rx + 8'd1, duty_rx, duty_low, duty_high);
            end else begin
              duty_level_next    = duty_write(duty_rest, duty_rx, duty_low, duty_high);
              actuator_mode_next = MODE_ON_TO_IDLE;
            end
          end
          MODE_TURNING_OFF: begin
            step_countdown_next = step_ticks;
            if (duty_rx != duty_low) begin
              duty_level_next = duty_write(duty_rx - 8'd1, duty_rx, duty_low, duty_high);
            end else begin
              duty_level_next    = duty_write(duty_rest, duty_rx, duty_low, duty_high);
              actuator_mode_next = MODE_OFF_TO_IDLE;
            end
          end
          MODE_ON_TO_IDLE:  actuator_mode_next = MODE_IDLE_ON;
          MODE_OFF_TO_IDLE: actuator_mode_next = MODE_IDLE_OFF;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pulse_run_length <= 8'd0;
      cooloff_count    <= 16'd0;
      cooling_flag     <= 1'b0;
      actuator_mode    <= MODE_IDLE_OFF;
      step_countdown   <= 16'd0;
      duty_level       <= RST_DUTY_REST;
    end else if (in_take) begin
      pulse_run_length <= pulse_run_length_next;
      cooloff_count    <= cooloff_count_next;
      cooling_flag     <= cooling_flag_next;
      actuator_mode    <= actuator_mode_next;
      step_countdown   <= step_countdown_next;
      duty_level       <= duty_level_next;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_take) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      duty_out          <= duty_level_next;
      actuator_mode_out <= mode_code(actuator_mode_next);
      pulse_accepted    <= accepted;
      cooling_off       <= cooling_flag_next;
    end
  end

endmodule
